// ----- rtl/core/huber_weighted_photometric_residual_defines.svh -----
// Assertion helpers used by hwpr_back.
`ifndef HUBER_WEIGHTED_PHOTOMETRIC_RESIDUAL_DEFINES_SVH
`define HUBER_WEIGHTED_PHOTOMETRIC_RESIDUAL_DEFINES_SVH

// Same-cycle check, disabled while in reset.
`define HWPR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Next-cycle check, disabled while in reset.
`define HWPR_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) pre |=> post) \
        else $error(msg);

`endif

// ----- rtl/core/hwpr_pkg.sv -----
package hwpr_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TRANS_X        = 3'd0,
        CFG_TRANS_Y        = 3'd1,
        CFG_TRANS_Z        = 3'd2,
        CFG_VARIANCE_GAIN  = 3'd3,
        CFG_PIXEL_NOISE_SQ = 3'd4,
        CFG_HUBER_WIDTH    = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic signed [31:0] trans_x;
        logic signed [31:0] trans_y;
        logic signed [31:0] trans_z;
        logic        [30:0] variance_gain;
        logic        [30:0] pixel_noise_sq;
        logic        [30:0] huber_width;
    } t_cfg;

    // one queued point; abs_res is |photo_residual| (needs 33 bits for -2^31)
    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] inv_depth;
        logic signed [31:0] photo_residual;
        logic signed [31:0] grad_x;
        logic signed [31:0] grad_y;
        logic        [30:0] depth_var;
        logic               last_point;
        logic        [32:0] abs_res;
    } t_item;

    typedef struct packed {
        logic        start;
        logic [63:0] num;
        logic [31:0] den;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic        busy;
        logic [63:0] quo;
    } t_div_rsp;

    localparam logic signed [65:0] S32_MAX_W = 66'sd2147483647;
    localparam logic signed [65:0] S32_MIN_W = -66'sd2147483648;

endpackage

// ----- rtl/core/hwpr_front.sv -----
module hwpr_front
    import hwpr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_pos_z,
    input  logic signed [31:0] i_inv_depth,
    input  logic signed [31:0] i_photo_residual,
    input  logic signed [31:0] i_grad_x,
    input  logic signed [31:0] i_grad_y,
    input  logic        [30:0] i_depth_var,
    input  logic               i_last_point,
    output t_item              o_item,
    output logic               o_item_valid,
    input  logic               i_item_pop
);

    localparam int DEPTH = 2;

    t_item              r_q [DEPTH];
    logic               r_wptr;
    logic               r_rptr;
    logic [1:0]         r_cnt;
    t_item              n_item;
    logic signed [32:0] res_ext;
    logic               push;
    logic               pop;

    assign o_in_ready   = (r_cnt != 2'(DEPTH));
    assign o_item_valid = (r_cnt != 2'd0);
    assign o_item       = r_q[r_rptr];
    assign push         = i_in_valid && o_in_ready;
    assign pop          = i_item_pop && o_item_valid;

    always_comb begin
        res_ext               = {i_photo_residual[31], i_photo_residual};
        n_item.pos_x          = i_pos_x;
        n_item.pos_y          = i_pos_y;
        n_item.pos_z          = i_pos_z;
        n_item.inv_depth      = i_inv_depth;
        n_item.photo_residual = i_photo_residual;
        n_item.grad_x         = i_grad_x;
        n_item.grad_y         = i_grad_y;
        n_item.depth_var      = i_depth_var;
        n_item.last_point     = i_last_point;
        n_item.abs_res        = res_ext[32] ? 33'(-res_ext) : 33'(res_ext);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (push) r_wptr <= ~r_wptr;
            if (pop)  r_rptr <= ~r_rptr;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wptr] <= n_item;
    end

endmodule

// ----- rtl/core/hwpr_div.sv -----
module hwpr_div
    import hwpr_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    localparam int STEPS = 64;

    logic        r_busy;
    logic        r_done;
    logic [5:0]  r_cnt;
    logic [31:0] r_rem;
    logic [63:0] r_quo;
    logic [31:0] r_den;
    logic [32:0] trial;
    logic [32:0] diff;
    logic        fits;

    // restoring division, one quotient bit per cycle
    always_comb begin
        trial = {r_rem, r_quo[63]};
        diff  = trial - {1'b0, r_den};
        fits  = (trial >= {1'b0, r_den});
    end

    assign o_rsp.done = r_done;
    assign o_rsp.busy = r_busy;
    assign o_rsp.quo  = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 6'd0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'(STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start && !r_busy) begin
            r_rem <= 32'd0;
            r_quo <= i_req.num;
            r_den <= i_req.den;
        end else if (r_busy) begin
            r_rem <= fits ? diff[31:0] : trial[31:0];
            r_quo <= {r_quo[62:0], fits};
        end
    end

endmodule

// ----- rtl/core/hwpr_back.sv -----
`include "huber_weighted_photometric_residual_defines.svh"

module hwpr_back
    import hwpr_pkg::*;
#(
    parameter int FRAC_BITS  = 16,
    parameter int MAX_POINTS = 524288
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  t_item       i_item,
    input  logic        i_item_valid,
    output logic        o_item_pop,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [30:0] o_point_weight,
    output logic [30:0] o_mean_residual,
    output logic        o_batch_done,
    output logic        o_saturated
);

    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam logic [CW-1:0]      MAX_CNT = CW'(MAX_POINTS);
    localparam logic signed [31:0] Q_ONE   = 32'sd1 <<< FRAC_BITS;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_MUL  = 6'b000010,
        ST_WB   = 6'b000100,
        ST_DIV  = 6'b001000,
        ST_SQRT = 6'b010000,
        ST_OUT  = 6'b100000
    } t_state;

    typedef enum logic [4:0] {
        U_S, U_ZZ, U_DEN, U_H0, U_N0, U_H1, U_N1, U_G0, U_G1, U_D0, U_D1,
        U_SQ, U_TW, U_WP, U_RT, U_WR, U_WH, U_WT, U_R2, U_CT, U_MN
    } t_uop;

    function automatic t_state uop_kind(input t_uop u);
        unique case (u)
            U_G0, U_G1, U_WP, U_WH, U_MN: uop_kind = ST_DIV;
            U_RT:                         uop_kind = ST_SQRT;
            default:                      uop_kind = ST_MUL;
        endcase
    endfunction

    // {flag, value}: clamp to the signed 32-bit range
    function automatic logic [32:0] sat32(input logic signed [65:0] v);
        priority if (v > S32_MAX_W) sat32 = {1'b1, 32'h7FFF_FFFF};
        else if (v < S32_MIN_W)     sat32 = {1'b1, 32'h8000_0000};
        else                        sat32 = {1'b0, v[31:0]};
    endfunction

    function automatic logic signed [32:0] sx(input logic signed [31:0] v);
        sx = {v[31], v};
    endfunction

    function automatic logic signed [32:0] zx(input logic [30:0] v);
        zx = {2'b00, v};
    endfunction

    t_state              r_state;
    t_uop                r_uop;
    t_item               r_item;
    logic                r_dgo;
    logic                r_sgo;
    logic                r_sat;
    logic [63:0]         r_sum;
    logic [CW-1:0]       r_cnt;

    logic signed [65:0]  r_prod;
    logic signed [65:0]  r_acc;
    logic signed [31:0]  r_s, r_t, r_den, r_n0, r_n1, r_g0, r_g1;
    logic signed [31:0]  r_wp, r_sqw, r_wh, r_weight;
    logic [30:0]         r_mean;
    logic [63:0]         r_sv, r_sres, r_sbit;

    logic                r_ovalid;
    logic [30:0]         r_opw, r_omean;
    logic                r_odone, r_osat;

    logic signed [32:0]  m_a, m_b;
    logic signed [65:0]  mul_p;
    logic signed [65:0]  prod_sh, n_diff, d_sum, tw_sum;
    logic [32:0]         q_fin, n_fin, d_fin, tw_fin;
    logic signed [31:0]  half_w;
    logic                wh_direct;
    logic                cnt_ok;

    logic signed [31:0]  div_a, div_b;
    logic signed [32:0]  a_ext, b_ext, a_mag, b_mag;
    logic                dz, dneg, div_fin;
    logic [32:0]         div_res;
    t_div_req            div_req;
    t_div_rsp            div_rsp;

    logic [63:0]         sq_sum, n_sv, n_sres;
    logic                sq_fits;

    logic [32:0]         res;
    logic                step_done, out_load;
    t_uop                n_uop;
    t_state              n_state;

    hwpr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // shared multiplier operand select
    always_comb begin
        unique case (r_uop)
            U_S:     begin m_a = zx(i_cfg.variance_gain); m_b = zx(r_item.depth_var); end
            U_ZZ:    begin m_a = sx(r_item.pos_z);        m_b = sx(r_item.pos_z);     end
            U_DEN:   begin m_a = sx(r_t);                 m_b = sx(r_item.inv_depth); end
            U_H0:    begin m_a = sx(i_cfg.trans_x);       m_b = sx(r_item.pos_z);     end
            U_N0:    begin m_a = sx(i_cfg.trans_z);       m_b = sx(r_item.pos_x);     end
            U_H1:    begin m_a = sx(i_cfg.trans_y);       m_b = sx(r_item.pos_z);     end
            U_N1:    begin m_a = sx(i_cfg.trans_z);       m_b = sx(r_item.pos_y);     end
            U_D0:    begin m_a = sx(r_item.grad_x);       m_b = sx(r_g0);             end
            U_D1:    begin m_a = sx(r_item.grad_y);       m_b = sx(r_g1);             end
            U_SQ:    begin m_a = sx(r_t);                 m_b = sx(r_t);              end
            U_TW:    begin m_a = sx(r_s);                 m_b = sx(r_t);              end
            U_WR:    begin m_a = $signed(r_item.abs_res); m_b = sx(r_sqw);            end
            U_WT:    begin m_a = sx(r_wh);                m_b = sx(r_wp);             end
            U_R2:    begin m_a = sx(r_item.photo_residual);
                           m_b = sx(r_item.photo_residual);                           end
            U_CT:    begin m_a = sx(r_weight);            m_b = sx(r_t);              end
            default: begin m_a = '0;                      m_b = '0;                   end
        endcase
        mul_p = m_a * m_b;
    end

    // product finishing (floor shift, then clamp)
    always_comb begin
        prod_sh = r_prod >>> FRAC_BITS;
        q_fin   = sat32(prod_sh);
        n_diff  = (r_acc - r_prod) >>> FRAC_BITS;
        n_fin   = sat32(n_diff);
        d_sum   = r_acc + prod_sh;
        d_fin   = sat32(d_sum);
        tw_sum  = $signed({35'd0, i_cfg.pixel_noise_sq})
                + $signed({{34{q_fin[31]}}, q_fin[31:0]});
        tw_fin  = sat32(tw_sum);
        half_w  = $signed({2'b00, i_cfg.huber_width[30:1]});
        wh_direct = ($signed(q_fin[31:0]) < half_w) || (q_fin[31:0] == 32'd0);
        cnt_ok  = (r_cnt < MAX_CNT);
    end

    // divider operands and result shaping
    always_comb begin
        unique case (r_uop)
            U_G0:    begin div_a = r_n0;   div_b = r_den; end
            U_G1:    begin div_a = r_n1;   div_b = r_den; end
            U_WP:    begin div_a = Q_ONE;  div_b = r_t;   end
            U_WH:    begin div_a = half_w; div_b = r_t;   end
            default: begin div_a = '0;     div_b = '0;    end
        endcase
        a_ext = sx(div_a);
        b_ext = sx(div_b);
        a_mag = a_ext[32] ? -a_ext : a_ext;
        b_mag = b_ext[32] ? -b_ext : b_ext;
        dneg  = div_a[31] ^ div_b[31];

        div_req.start = 1'b0;
        div_req.num   = 64'(a_mag) << FRAC_BITS;
        div_req.den   = b_mag[31:0];
        if (r_uop == U_MN) begin
            div_req.num = r_sum;
            div_req.den = 32'(r_cnt);
            dz          = (r_cnt == '0);
        end else begin
            dz          = (div_b == 32'sd0);
        end
        div_req.start = (r_state == ST_DIV) && !r_dgo && !dz;
        div_fin       = (r_state == ST_DIV) && ((!r_dgo && dz) || div_rsp.done);

        if (r_uop == U_MN) begin
            // an empty batch gives mean 0 without a flag
            priority if (dz)                          div_res = 33'd0;
            else if (div_rsp.quo > 64'h7FFF_FFFF)     div_res = {1'b1, 32'h7FFF_FFFF};
            else                                      div_res = {1'b0, div_rsp.quo[31:0]};
        end else begin
            priority if (dz)
                div_res = div_a[31] ? {1'b1, 32'h8000_0000} : {1'b1, 32'h7FFF_FFFF};
            else if (!dneg && div_rsp.quo > 64'h7FFF_FFFF)
                div_res = {1'b1, 32'h7FFF_FFFF};
            else if (dneg && div_rsp.quo > 64'h8000_0000)
                div_res = {1'b1, 32'h8000_0000};
            else if (dneg)
                div_res = {1'b0, ~div_rsp.quo[31:0] + 32'd1};
            else
                div_res = {1'b0, div_rsp.quo[31:0]};
        end
    end

    // square root step
    always_comb begin
        sq_sum  = r_sres + r_sbit;
        sq_fits = (r_sv >= sq_sum);
        n_sv    = sq_fits ? r_sv - sq_sum : r_sv;
        n_sres  = sq_fits ? (r_sres >> 1) + r_sbit : r_sres >> 1;
    end

    // step result and sequencing
    always_comb begin
        priority if (r_state == ST_DIV) res = div_res;
        else if (r_state == ST_SQRT)    res = {1'b0, n_sres[31:0]};
        else begin
            unique case (r_uop)
                // partial products are only clamped once combined
                U_H0, U_H1, U_D0: res = {1'b0, q_fin[31:0]};
                U_N0, U_N1: res = n_fin;
                U_D1:       res = d_fin;
                U_TW:       res = {q_fin[32] | tw_fin[32], tw_fin[31:0]};
                U_CT:       res = {q_fin[32] | ~cnt_ok, q_fin[31:0]};
                U_WR: begin
                    if ($signed(q_fin[31:0]) < half_w) res = {q_fin[32], Q_ONE};
                    else if (q_fin[31:0] == 32'd0)     res = {1'b1, 32'd0};
                    else                               res = q_fin;
                end
                default:    res = q_fin;
            endcase
        end

        step_done = (r_state == ST_WB) || div_fin
                 || ((r_state == ST_SQRT) && r_sgo && r_sbit[0]);

        n_uop = t_uop'(5'(r_uop) + 5'd1);
        if (r_uop == U_WR) n_uop = wh_direct ? U_WT : U_WH;
        if ((r_uop == U_MN) || ((r_uop == U_CT) && !r_item.last_point)) n_state = ST_OUT;
        else                                                              n_state = uop_kind(n_uop);

        out_load   = (r_state == ST_OUT) && (!r_ovalid || i_out_ready);
        o_item_pop = (r_state == ST_IDLE) && i_item_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_uop    <= U_S;
            r_dgo    <= 1'b0;
            r_sgo    <= 1'b0;
            r_sum    <= 64'd0;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (div_req.start) r_dgo <= 1'b1;
            if (div_rsp.done)  r_dgo <= 1'b0;
            if ((r_state == ST_SQRT) && !r_sgo) r_sgo <= 1'b1;
            if ((r_state == ST_SQRT) && r_sgo && r_sbit[0]) r_sgo <= 1'b0;

            unique case (r_state)
                ST_IDLE: begin
                    if (i_item_valid) begin
                        r_uop   <= U_S;
                        r_state <= ST_MUL;
                    end
                end
                ST_MUL:  r_state <= ST_WB;
                ST_OUT:  if (out_load) r_state <= ST_IDLE;
                default: begin
                    if (step_done) begin
                        r_uop   <= n_uop;
                        r_state <= n_state;
                    end
                end
            endcase

            if ((r_state == ST_WB) && (r_uop == U_CT) && cnt_ok) begin
                r_sum <= r_sum + 64'(q_fin[31:0]);
                r_cnt <= r_cnt + CW'(1);
            end
            if (div_fin && (r_uop == U_MN)) begin
                r_sum <= 64'd0;
                r_cnt <= '0;
            end

            if (out_load)         r_ovalid <= 1'b1;
            else if (i_out_ready) r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_IDLE) && i_item_valid) begin
            r_item <= i_item;
            r_sat  <= 1'b0;
        end
        if (r_state == ST_MUL) r_prod <= mul_p;
        if ((r_state == ST_SQRT) && !r_sgo) begin
            r_sv   <= 64'(r_wp[30:0]) << FRAC_BITS;
            r_sres <= 64'd0;
            r_sbit <= 64'h4000_0000_0000_0000;
        end else if (r_state == ST_SQRT) begin
            r_sv   <= n_sv;
            r_sres <= n_sres;
            r_sbit <= r_sbit >> 2;
        end
        if (step_done) begin
            r_sat <= r_sat | res[32];
            unique case (r_uop)
                U_S:                          r_s      <= res[31:0];
                U_ZZ, U_D1, U_SQ, U_TW, U_R2: r_t      <= res[31:0];
                U_DEN:                        r_den    <= res[31:0];
                U_H0, U_H1:                   r_acc    <= r_prod;
                U_D0:                         r_acc    <= prod_sh;
                U_N0:                         r_n0     <= res[31:0];
                U_N1:                         r_n1     <= res[31:0];
                U_G0:                         r_g0     <= res[31:0];
                U_G1:                         r_g1     <= res[31:0];
                U_WP:                         r_wp     <= res[31:0];
                U_RT:                         r_sqw    <= res[31:0];
                U_WR: begin
                    if (wh_direct) r_wh <= res[31:0];
                    else           r_t  <= res[31:0];
                end
                U_WH:                         r_wh     <= res[31:0];
                U_WT:                         r_weight <= res[31:0];
                U_CT:                         r_mean   <= 31'd0;
                U_MN:                         r_mean   <= res[30:0];
                default: ;
            endcase
        end
        if (out_load) begin
            r_opw   <= r_weight[30:0];
            r_omean <= r_mean;
            r_odone <= r_item.last_point;
            r_osat  <= r_sat;
        end
    end

    assign o_out_valid     = r_ovalid;
    assign o_point_weight  = r_opw;
    assign o_mean_residual = r_omean;
    assign o_batch_done    = r_odone;
    assign o_saturated     = r_osat;

    `HWPR_ASSERT(a_div_done_in_div, div_rsp.done |-> (r_state == ST_DIV), "divider done outside a division step")
    `HWPR_ASSERT(a_div_quiet_idle, (r_state == ST_IDLE) |-> !div_rsp.busy, "divider busy while idle")
    `HWPR_ASSERT(a_batch_cleared, ((r_state == ST_OUT) && r_item.last_point) |-> (r_cnt == '0), "batch state not cleared")
    `HWPR_ASSERT_NEXT(a_mul_then_wb, (r_state == ST_MUL), (r_state == ST_WB), "product not written back")

endmodule

// ----- rtl/core/huber_weighted_photometric_residual.sv -----
// Huber-weighted photometric residual: takes one warped point per beat and
// returns one result beat with the point weight (Huber factor times variance
// weight), the saturation flag and, on the point marked last, the batch mean of
// the weighted squared residual. Items queue two deep in front; the back end
// runs each point through one shared 33x33 multiplier (fifteen products), a
// shared restoring divider (three quotients per point, one more when the Huber
// clamp is active, one more for the batch mean; a zero divisor bypasses the
// divider) and a bit-pair square root. Configuration is written through the
// plain write port; the user must write it only while idle, which the block
// itself does not enforce.
module huber_weighted_photometric_residual
    import hwpr_pkg::*;
#(
    parameter int FRAC_BITS  = 16,
    parameter int MAX_POINTS = 524288
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic signed [31:0]    i_pos_x,
    input  logic signed [31:0]    i_pos_y,
    input  logic signed [31:0]    i_pos_z,
    input  logic signed [31:0]    i_inv_depth,
    input  logic signed [31:0]    i_photo_residual,
    input  logic signed [31:0]    i_grad_x,
    input  logic signed [31:0]    i_grad_y,
    input  logic        [30:0]    i_depth_var,
    input  logic                  i_last_point,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic        [30:0]    o_point_weight,
    output logic        [30:0]    o_mean_residual,
    output logic                  o_batch_done,
    output logic                  o_saturated
);

    // 1.0 in the chosen fixed-point format
    localparam logic [30:0] ONE_Q = 31'(64'd1 << FRAC_BITS);

    t_cfg  r_cfg;
    t_item item;
    logic  item_valid;
    logic  item_pop;

    // configuration registers; writes beyond the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.trans_x        <= 32'sd0;
            r_cfg.trans_y        <= 32'sd0;
            r_cfg.trans_z        <= 32'sd0;
            r_cfg.variance_gain  <= ONE_Q;
            r_cfg.pixel_noise_sq <= ONE_Q;
            r_cfg.huber_width    <= ONE_Q;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_TRANS_X:        r_cfg.trans_x        <= i_cfg_data;
                CFG_TRANS_Y:        r_cfg.trans_y        <= i_cfg_data;
                CFG_TRANS_Z:        r_cfg.trans_z        <= i_cfg_data;
                CFG_VARIANCE_GAIN:  r_cfg.variance_gain  <= i_cfg_data[30:0];
                CFG_PIXEL_NOISE_SQ: r_cfg.pixel_noise_sq <= i_cfg_data[30:0];
                CFG_HUBER_WIDTH:    r_cfg.huber_width    <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // input queue
    hwpr_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_pos_x          (i_pos_x),
        .i_pos_y          (i_pos_y),
        .i_pos_z          (i_pos_z),
        .i_inv_depth      (i_inv_depth),
        .i_photo_residual (i_photo_residual),
        .i_grad_x         (i_grad_x),
        .i_grad_y         (i_grad_y),
        .i_depth_var      (i_depth_var),
        .i_last_point     (i_last_point),
        .o_item           (item),
        .o_item_valid     (item_valid),
        .i_item_pop       (item_pop)
    );

    // arithmetic sequencer, accumulator and output register
    hwpr_back #(
        .FRAC_BITS  (FRAC_BITS),
        .MAX_POINTS (MAX_POINTS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_item          (item),
        .i_item_valid    (item_valid),
        .o_item_pop      (item_pop),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_point_weight  (o_point_weight),
        .o_mean_residual (o_mean_residual),
        .o_batch_done    (o_batch_done),
        .o_saturated     (o_saturated)
    );

endmodule
